/* hw/rtl/abdv_pkg.sv */
`default_nettype none
package abdv_pkg;

  localparam int HistoryDepthDefault = 5;
  localparam logic [30:0] NsPerSec = 31'd1000000000;

  localparam logic [1:0] SelX   = 2'd0;
  localparam logic [1:0] SelY   = 2'd1;
  localparam logic [1:0] SelZ   = 2'd2;
  localparam logic [1:0] SelSec = 2'd3;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        stamp_sec;
    logic [29:0]        stamp_nsec;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } velocity_t;

  typedef struct packed {
    logic       accept;
    logic       load_prev;
    logic       load_cur;
    logic       mul;
    logic       add_dt;
    logic       pair_zero;
    logic       div_start;
    logic       div_store;
    logic       final_div;
    logic       accumulate;
    logic       publish;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic same_pos;
    logic dt_pos;
    logic div_done;
  } status_t;

endpackage
`default_nettype wire

/* hw/rtl/abdv_div.sv */
`default_nettype none
module abdv_div #(
  parameter int NW = 68,
  parameter int DW = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);

  localparam int CW = $clog2(NW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [DW:0]   shifted;
  logic [DW:0]   trial;

  assign shifted = {rem, quo[NW-1]};
  assign trial   = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(NW - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      if (!trial[DW]) begin
        rem <= trial[DW-1:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= shifted[DW-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/abdv_dp.sv */
`default_nettype none
module abdv_dp import abdv_pkg::*; #(
  parameter int HISTORY_DEPTH = HistoryDepthDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire sample_t sample,
  input  wire cmd_t    cmd,
  output status_t      status,
  output velocity_t    velocity
);

  localparam int IW = $clog2(HISTORY_DEPTH);
  localparam int SW = 64 + $clog2(HISTORY_DEPTH);
  localparam int DN = (SW + 3) / 4;
  localparam int PW = 4 * DN;
  localparam int CNW = $clog2(DN);

  sample_t ring [HISTORY_DEPTH];
  logic [IW-1:0] slot;
  logic [IW-1:0] rd_idx;
  sample_t prev;
  sample_t cur;

  logic signed [63:0] num [3];
  logic signed [63:0] pair_vel [3];
  logic signed [SW-1:0] sum [3];
  logic signed [31:0] res [3];
  logic signed [63:0] dt_mul;
  logic signed [63:0] dt;
  logic same_pos;
  logic div_neg;

  logic signed [32:0] dx, dy, dz, dsec;
  logic signed [30:0] dnsec;
  logic signed [32:0] mul_a;
  logic signed [63:0] prod;
  logic div_num_neg;
  logic div_done;
  logic [SW-1:0] quo;
  logic [63:0] num_abs;
  logic [SW-1:0] sum_abs;
  logic signed [SW-1:0] sum_sel;
  logic signed [63:0] num_sel;
  logic signed [31:0] sat;

  logic           pdiv_start;
  logic           cdiv_start;
  logic           cdiv_busy;
  logic           cdiv_done;
  logic [CNW-1:0] cdiv_cnt;
  logic [3:0]     cdiv_rem;
  logic [PW-1:0]  cdiv_q;
  logic [7:0]     cdiv_part;
  logic [7:0]     cdiv_step;
  logic [SW-1:0]  cquo;

  function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
    return (i == IW'(HISTORY_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // one quotient digit and remainder of an 8-bit partial value by the pair count
  function automatic logic [7:0] digit_div(input logic [7:0] v);
    logic [3:0] q;
    logic [7:0] r;
    q = '0;
    r = v;
    for (int j = 1; j < 16; j++) begin
      if (v >= 8'(j * (HISTORY_DEPTH - 1))) begin
        q = 4'(j);
        r = v - 8'(j * (HISTORY_DEPTH - 1));
      end
    end
    return {q, r[3:0]};
  endfunction

  assign dx    = {cur.pos_x[31], cur.pos_x} - {prev.pos_x[31], prev.pos_x};
  assign dy    = {cur.pos_y[31], cur.pos_y} - {prev.pos_y[31], prev.pos_y};
  assign dz    = {cur.pos_z[31], cur.pos_z} - {prev.pos_z[31], prev.pos_z};
  assign dsec  = {1'b0, cur.stamp_sec} - {1'b0, prev.stamp_sec};
  assign dnsec = {1'b0, cur.stamp_nsec} - {1'b0, prev.stamp_nsec};

  always_comb begin
    case (cmd.sel)
      SelX:    mul_a = dx;
      SelY:    mul_a = dy;
      SelZ:    mul_a = dz;
      default: mul_a = dsec;
    endcase
  end

  assign prod = mul_a * $signed(NsPerSec);

  assign num_sel = num[cmd.sel[1:0] == SelSec ? SelX : cmd.sel];
  assign sum_sel = sum[cmd.sel[1:0] == SelSec ? SelX : cmd.sel];
  assign num_abs = num_sel[63] ? 64'(-num_sel) : 64'(num_sel);
  assign sum_abs = sum_sel[SW-1] ? SW'(-sum_sel) : SW'(sum_sel);
  assign div_num_neg = cmd.final_div ? sum_sel[SW-1] : num_sel[63];

  assign pdiv_start = cmd.div_start && !cmd.final_div;
  assign cdiv_start = cmd.div_start && cmd.final_div;

  abdv_div #(.NW(SW), .DW(64)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (pdiv_start),
    .num   (SW'(num_abs)),
    .den   (dt),
    .done  (div_done),
    .quo   (quo)
  );

  // radix-16 divide of the sum magnitude by the pair count
  assign cdiv_part = {cdiv_rem, cdiv_q[PW-1 -: 4]};
  assign cdiv_step = digit_div(cdiv_part);
  assign cquo      = cdiv_q[SW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cdiv_busy <= 1'b0;
      cdiv_done <= 1'b0;
      cdiv_cnt  <= '0;
    end else if (cdiv_start) begin
      cdiv_busy <= 1'b1;
      cdiv_done <= 1'b0;
      cdiv_cnt  <= CNW'(DN - 1);
    end else if (cdiv_busy) begin
      if (cdiv_cnt == '0) begin
        cdiv_busy <= 1'b0;
        cdiv_done <= 1'b1;
      end else begin
        cdiv_cnt <= cdiv_cnt - 1'b1;
      end
    end else begin
      cdiv_done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cdiv_start) begin
      cdiv_rem <= '0;
      cdiv_q   <= PW'(sum_abs);
    end else if (cdiv_busy) begin
      cdiv_q   <= {cdiv_q[PW-5:0], cdiv_step[7:4]};
      cdiv_rem <= cdiv_step[3:0];
    end
  end

  // saturate the final magnitude back to 32 bits
  always_comb begin
    if (div_neg) begin
      if (cquo > SW'(64'h8000_0000)) sat = 32'sh8000_0000;
      else sat = 32'(-cquo[31:0]);
    end else begin
      if (cquo > SW'(64'h7fff_ffff)) sat = 32'sh7fff_ffff;
      else sat = cquo[31:0];
    end
  end

  assign status.same_pos = same_pos;
  assign status.dt_pos   = !dt[63] && (dt != '0);
  assign status.div_done = div_done || cdiv_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) ring[i] <= '0;
    end else if (cmd.accept) begin
      ring[slot] <= sample;
      slot       <= nxt(slot);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_idx <= nxt(slot);
      for (int a = 0; a < 3; a++) begin
        pair_vel[a] <= '0;
        sum[a]      <= '0;
      end
    end
    if (cmd.load_prev) begin
      prev   <= ring[rd_idx];
      rd_idx <= nxt(rd_idx);
    end
    if (cmd.load_cur) begin
      cur    <= ring[rd_idx];
      rd_idx <= nxt(rd_idx);
    end
    if (cmd.mul) begin
      if (cmd.sel == SelSec) dt_mul <= prod;
      else num[cmd.sel] <= prod;
    end
    if (cmd.add_dt) begin
      dt       <= dt_mul + {{33{dnsec[30]}}, dnsec};
      same_pos <= (cur.pos_x == prev.pos_x) && (cur.pos_y == prev.pos_y)
                  && (cur.pos_z == prev.pos_z);
    end
    if (cmd.pair_zero) begin
      for (int a = 0; a < 3; a++) pair_vel[a] <= '0;
    end
    if (cmd.div_start) div_neg <= div_num_neg;
    if (cmd.div_store) begin
      if (cmd.final_div) res[cmd.sel] <= sat;
      else pair_vel[cmd.sel] <= div_neg ? 64'(-quo[63:0]) : quo[63:0];
    end
    if (cmd.accumulate) begin
      prev <= cur;
      for (int a = 0; a < 3; a++) sum[a] <= sum[a] + SW'(pair_vel[a]);
    end
    if (cmd.publish) begin
      velocity.vel_x <= res[0];
      velocity.vel_y <= res[1];
      velocity.vel_z <= res[2];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/abdv_ctrl.sv */
`default_nettype none
module abdv_ctrl import abdv_pkg::*; #(
  parameter int HISTORY_DEPTH = HistoryDepthDefault
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    sample_valid,
  output logic         sample_stall,
  output logic         velocity_valid,
  input  wire logic    velocity_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam int PW = $clog2(HISTORY_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_PREV, S_CUR, S_MUL, S_DT, S_DECIDE, S_DIVS, S_DIVW,
    S_ACC, S_FDIVS, S_FDIVW, S_DONE
  } state_t;

  state_t        state;
  logic [1:0]    sel;
  logic [PW-1:0] pair_cnt;
  logic          last_pair;
  logic          out_free;

  assign sample_stall = (state != S_IDLE);
  assign last_pair    = (pair_cnt == PW'(HISTORY_DEPTH - 2));
  assign out_free     = !velocity_valid || !velocity_stall;

  always_comb begin
    cmd            = '0;
    cmd.sel        = sel;
    cmd.final_div  = (state == S_FDIVS) || (state == S_FDIVW);
    case (state)
      S_IDLE:   cmd.accept    = sample_valid;
      S_PREV:   cmd.load_prev = 1'b1;
      S_CUR:    cmd.load_cur  = 1'b1;
      S_MUL:    cmd.mul       = 1'b1;
      S_DT:     cmd.add_dt    = 1'b1;
      S_DECIDE: cmd.pair_zero = status.same_pos;
      S_DIVS:   cmd.div_start = 1'b1;
      S_DIVW:   cmd.div_store = status.div_done;
      S_ACC:    cmd.accumulate = 1'b1;
      S_FDIVS:  cmd.div_start = 1'b1;
      S_FDIVW:  cmd.div_store = status.div_done;
      S_DONE:   cmd.publish   = out_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      sel            <= SelX;
      pair_cnt       <= '0;
      velocity_valid <= 1'b0;
    end else begin
      if (velocity_valid && !velocity_stall && state != S_DONE) velocity_valid <= 1'b0;
      case (state)
        S_IDLE: if (sample_valid) state <= S_PREV;
        S_PREV: begin
          pair_cnt <= '0;
          state    <= S_CUR;
        end
        S_CUR: begin
          sel   <= SelX;
          state <= S_MUL;
        end
        S_MUL: begin
          if (sel == SelSec) state <= S_DT;
          sel <= sel + 2'd1;
        end
        S_DT: state <= S_DECIDE;
        S_DECIDE: begin
          sel <= SelX;
          if (status.same_pos || !status.dt_pos) state <= S_ACC;
          else state <= S_DIVS;
        end
        S_DIVS: state <= S_DIVW;
        S_DIVW: if (status.div_done) begin
          if (sel == SelZ) state <= S_ACC;
          else begin
            sel   <= sel + 2'd1;
            state <= S_DIVS;
          end
        end
        S_ACC: begin
          sel <= SelX;
          if (last_pair) state <= S_FDIVS;
          else begin
            pair_cnt <= pair_cnt + 1'b1;
            state    <= S_CUR;
          end
        end
        S_FDIVS: state <= S_FDIVW;
        S_FDIVW: if (status.div_done) begin
          if (sel == SelZ) state <= S_DONE;
          else begin
            sel   <= sel + 2'd1;
            state <= S_FDIVS;
          end
        end
        S_DONE: if (out_free) begin
          velocity_valid <= 1'b1;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == S_DIVW || state == S_FDIVW))
    else $error("divider finished outside a wait state");
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!velocity_valid || !velocity_stall))
    else $error("result overwritten while still pending");
  a_pair_bound: assert property (@(posedge clk) disable iff (rst)
    pair_cnt <= PW'(HISTORY_DEPTH - 2))
    else $error("pair count out of range");
  a_sel_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> sel != SelSec)
    else $error("divide started on time select");
`endif

endmodule
`default_nettype wire

/* hw/rtl/averaged_backward_difference_velocity.sv */
// request to result: the serial pair divider (SW = 64 + clog2(HISTORY_DEPTH) quotient bits)
// makes one quotient bit per cycle over up to 3*(HISTORY_DEPTH-1) divides, fewer when a pair
// skips its divides; the final divides by the pair count (DN = ceil(SW/4) digits) take four
// bits per cycle; the result then waits while velocity_stall holds it
// a new request is accepted only once the previous result is published (sample_stall high)
// reset: synchronous, clears the history ring, write slot and control
`default_nettype none
module averaged_backward_difference_velocity import abdv_pkg::*; #(
  parameter int HISTORY_DEPTH = HistoryDepthDefault
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      sample_valid,
  output logic           sample_stall,
  input  wire sample_t   sample,
  output logic           velocity_valid,
  input  wire logic      velocity_stall,
  output velocity_t      velocity
);

  cmd_t    cmd;
  status_t status;

  abdv_ctrl #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .velocity_valid (velocity_valid),
    .velocity_stall (velocity_stall),
    .status         (status),
    .cmd            (cmd)
  );

  abdv_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .cmd      (cmd),
    .status   (status),
    .velocity (velocity)
  );

endmodule
`default_nettype wire
